>>> src/mstw_pkg.sv
// ----------------------------------------------------------------------------
// mstw_pkg
// Shared types, widths and command codes for the spanning tree weight block.
// ----------------------------------------------------------------------------
`default_nettype none

package mstw_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 1024;

  localparam int unsigned VW = 10;   // vertex index width
  localparam int unsigned CW = 11;   // count / vertex_count width
  localparam int unsigned WW = 16;   // edge weight width
  localparam int unsigned SW = 26;   // weight sum width
  localparam int unsigned HAW = 10;  // heap memory address width

  typedef struct packed {
    logic [WW-1:0] w;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
  } heap_entry_t;

  // datapath operation codes
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_PUSH_INIT = 5'd2;
  localparam logic [4:0] OP_PUSH_RD   = 5'd3;
  localparam logic [4:0] OP_PUSH_CMP  = 5'd4;
  localparam logic [4:0] OP_PUSH_FIN  = 5'd5;
  localparam logic [4:0] OP_CLR_INIT  = 5'd6;
  localparam logic [4:0] OP_CLR       = 5'd7;
  localparam logic [4:0] OP_POP_TOP   = 5'd8;
  localparam logic [4:0] OP_POP_LAST  = 5'd9;
  localparam logic [4:0] OP_POP_INIT  = 5'd10;
  localparam logic [4:0] OP_SD_RD1    = 5'd11;
  localparam logic [4:0] OP_SD_RD2    = 5'd12;
  localparam logic [4:0] OP_SD_CMP    = 5'd13;
  localparam logic [4:0] OP_POP_FIN   = 5'd14;
  localparam logic [4:0] OP_FA_INIT   = 5'd15;
  localparam logic [4:0] OP_FIND_RD   = 5'd16;
  localparam logic [4:0] OP_FA_CHK    = 5'd17;
  localparam logic [4:0] OP_FB_INIT   = 5'd18;
  localparam logic [4:0] OP_FB_CHK    = 5'd19;
  localparam logic [4:0] OP_UN1       = 5'd20;
  localparam logic [4:0] OP_UN2       = 5'd21;
  localparam logic [4:0] OP_OUT       = 5'd22;

  typedef struct packed {
    logic [4:0] op;
  } mstw_cmd_t;

  typedef struct packed {
    logic is_compute;
    logic add_ok;
    logic i_gt1;
    logic gt;
    logic clr_last;
    logic acc_done;
    logic empty;
    logic has_child;
    logic brk;
    logic top_bad;
    logic par_neg;
    logic same_root;
    logic out_free;
  } mstw_sts_t;

endpackage

`default_nettype wire

>>> src/mstw_ctrl.sv
// ----------------------------------------------------------------------------
// mstw_ctrl
// Sequencer for heap insert, union-find clear, pop/sift and find/union.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mstw_pkg::mstw_sts_t sts,
  output mstw_pkg::mstw_cmd_t     cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISP      = 5'd1;
  localparam logic [4:0] S_PUSH_INIT = 5'd2;
  localparam logic [4:0] S_PUSH_CHK  = 5'd3;
  localparam logic [4:0] S_PUSH_RD   = 5'd4;
  localparam logic [4:0] S_PUSH_CMP  = 5'd5;
  localparam logic [4:0] S_PUSH_FIN  = 5'd6;
  localparam logic [4:0] S_CLR_INIT  = 5'd7;
  localparam logic [4:0] S_CLR       = 5'd8;
  localparam logic [4:0] S_LOOP      = 5'd9;
  localparam logic [4:0] S_POP_TOP   = 5'd10;
  localparam logic [4:0] S_POP_LAST  = 5'd11;
  localparam logic [4:0] S_POP_INIT  = 5'd12;
  localparam logic [4:0] S_SIFT      = 5'd13;
  localparam logic [4:0] S_SD_RD1    = 5'd14;
  localparam logic [4:0] S_SD_RD2    = 5'd15;
  localparam logic [4:0] S_SD_CMP    = 5'd16;
  localparam logic [4:0] S_POP_FIN   = 5'd17;
  localparam logic [4:0] S_FA_INIT   = 5'd18;
  localparam logic [4:0] S_FA_RD     = 5'd19;
  localparam logic [4:0] S_FA_CHK    = 5'd20;
  localparam logic [4:0] S_FB_INIT   = 5'd21;
  localparam logic [4:0] S_FB_RD     = 5'd22;
  localparam logic [4:0] S_FB_CHK    = 5'd23;
  localparam logic [4:0] S_UNION_CHK = 5'd24;
  localparam logic [4:0] S_UN1       = 5'd25;
  localparam logic [4:0] S_UN2       = 5'd26;
  localparam logic [4:0] S_FINISH    = 5'd27;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = mstw_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = mstw_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_compute) state_nxt = S_CLR_INIT;
        else if (sts.add_ok) state_nxt = S_PUSH_INIT;
        else state_nxt = S_IDLE;
      end
      S_PUSH_INIT: begin
        cmd.op    = mstw_pkg::OP_PUSH_INIT;
        state_nxt = S_PUSH_CHK;
      end
      S_PUSH_CHK: state_nxt = sts.i_gt1 ? S_PUSH_RD : S_PUSH_FIN;
      S_PUSH_RD: begin
        cmd.op    = mstw_pkg::OP_PUSH_RD;
        state_nxt = S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        cmd.op    = mstw_pkg::OP_PUSH_CMP;
        state_nxt = sts.gt ? S_PUSH_CHK : S_IDLE;
      end
      S_PUSH_FIN: begin
        cmd.op    = mstw_pkg::OP_PUSH_FIN;
        state_nxt = S_IDLE;
      end
      S_CLR_INIT: begin
        cmd.op    = mstw_pkg::OP_CLR_INIT;
        state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.op    = mstw_pkg::OP_CLR;
        if (sts.clr_last) state_nxt = S_LOOP;
      end
      S_LOOP: state_nxt = (sts.acc_done || sts.empty) ? S_FINISH : S_POP_TOP;
      S_POP_TOP: begin
        cmd.op    = mstw_pkg::OP_POP_TOP;
        state_nxt = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.op    = mstw_pkg::OP_POP_LAST;
        state_nxt = S_POP_INIT;
      end
      S_POP_INIT: begin
        cmd.op    = mstw_pkg::OP_POP_INIT;
        state_nxt = S_SIFT;
      end
      S_SIFT: state_nxt = sts.has_child ? S_SD_RD1 : S_POP_FIN;
      S_SD_RD1: begin
        cmd.op    = mstw_pkg::OP_SD_RD1;
        state_nxt = S_SD_RD2;
      end
      S_SD_RD2: begin
        cmd.op    = mstw_pkg::OP_SD_RD2;
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.op    = mstw_pkg::OP_SD_CMP;
        state_nxt = sts.brk ? S_POP_FIN : S_SIFT;
      end
      S_POP_FIN: begin
        cmd.op    = mstw_pkg::OP_POP_FIN;
        state_nxt = sts.top_bad ? S_LOOP : S_FA_INIT;
      end
      S_FA_INIT: begin
        cmd.op    = mstw_pkg::OP_FA_INIT;
        state_nxt = S_FA_RD;
      end
      S_FA_RD: begin
        cmd.op    = mstw_pkg::OP_FIND_RD;
        state_nxt = S_FA_CHK;
      end
      S_FA_CHK: begin
        cmd.op    = mstw_pkg::OP_FA_CHK;
        state_nxt = sts.par_neg ? S_FB_INIT : S_FA_RD;
      end
      S_FB_INIT: begin
        cmd.op    = mstw_pkg::OP_FB_INIT;
        state_nxt = S_FB_RD;
      end
      S_FB_RD: begin
        cmd.op    = mstw_pkg::OP_FIND_RD;
        state_nxt = S_FB_CHK;
      end
      S_FB_CHK: begin
        cmd.op    = mstw_pkg::OP_FB_CHK;
        state_nxt = sts.par_neg ? S_UNION_CHK : S_FB_RD;
      end
      S_UNION_CHK: state_nxt = sts.same_root ? S_LOOP : S_UN1;
      S_UN1: begin
        cmd.op    = mstw_pkg::OP_UN1;
        state_nxt = S_UN2;
      end
      S_UN2: begin
        cmd.op    = mstw_pkg::OP_UN2;
        state_nxt = S_LOOP;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op    = mstw_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/mstw_dp.sv
// ----------------------------------------------------------------------------
// mstw_dp
// Edge heap memory, union-find memory, working registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mstw_pkg::mstw_cmd_t         cmd,
  output mstw_pkg::mstw_sts_t              sts,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mstw_pkg::CW-1:0]     cfg_wr_data,
  input  wire logic                        in_kind,
  input  wire logic [mstw_pkg::VW-1:0]     in_endpoint_a,
  input  wire logic [mstw_pkg::VW-1:0]     in_endpoint_b,
  input  wire logic [mstw_pkg::WW-1:0]     in_edge_weight,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic [mstw_pkg::SW-1:0]          out_total_weight
);

  localparam int unsigned VW = mstw_pkg::VW;
  localparam int unsigned CW = mstw_pkg::CW;
  localparam int unsigned SW = mstw_pkg::SW;
  localparam int unsigned HAW = mstw_pkg::HAW;
  localparam logic [CW-1:0] MAXV = CW'(mstw_pkg::MAX_VERTICES);
  localparam logic [CW-1:0] MAXE = CW'(mstw_pkg::MAX_EDGES);

  // memories
  mstw_pkg::heap_entry_t heap_mem [mstw_pkg::MAX_EDGES];
  logic [CW-1:0]         par_mem  [mstw_pkg::MAX_VERTICES];

  mstw_pkg::heap_entry_t heap_q;
  logic [CW-1:0]         par_q;

  logic                  heap_we;
  logic [HAW-1:0]        heap_addr;
  mstw_pkg::heap_entry_t heap_wdata;
  logic                  par_we;
  logic [VW-1:0]         par_addr;
  logic [CW-1:0]         par_wdata;

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_addr] <= heap_wdata;
    heap_q <= heap_mem[heap_addr];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_addr] <= par_wdata;
    par_q <= par_mem[par_addr];
  end

  // registers
  logic [CW-1:0] vcount_r, vcount_nxt;
  logic          kind_r, kind_nxt;
  mstw_pkg::heap_entry_t e_r, e_nxt;
  mstw_pkg::heap_entry_t top_r, top_nxt;
  mstw_pkg::heap_entry_t last_r, last_nxt;
  mstw_pkg::heap_entry_t ch_r, ch_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;           // heap position, 1 based
  logic [VW-1:0] k_r, k_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [VW-1:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic [CW-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [VW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [SW-1:0] out_total_r, out_total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= CW'(1);
      cnt_r       <= '0;
      acc_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcount_r    <= vcount_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    e_r          <= e_nxt;
    top_r        <= top_nxt;
    last_r       <= last_nxt;
    ch_r         <= ch_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    v_r          <= v_nxt;
    r1_r         <= r1_nxt;
    r2_r         <= r2_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
  end

  // effective vertex count, saturated to 1..MAX_VERTICES
  logic [CW-1:0] n_eff, n_m1;
  always_comb begin
    if (vcount_r == '0) n_eff = CW'(1);
    else if (vcount_r > MAXV) n_eff = MAXV;
    else n_eff = vcount_r;
  end
  assign n_m1 = n_eff - CW'(1);

  // sift-down child selection
  logic [CW:0]           c2;
  logic                  use_right;
  mstw_pkg::heap_entry_t chosen;
  logic [CW:0]           chosen_idx;
  assign c2         = {i_r, 1'b0};
  assign use_right  = (c2 != {1'b0, cnt_r}) && (heap_q.w < ch_r.w);
  assign chosen     = use_right ? heap_q : ch_r;
  assign chosen_idx = use_right ? (c2 + (CW+1)'(1)) : c2;

  logic [VW-1:0] big_root, small_root;
  assign big_root   = ($signed(p1_r) < $signed(p2_r)) ? r1_r : r2_r;
  assign small_root = ($signed(p1_r) < $signed(p2_r)) ? r2_r : r1_r;

  logic [HAW-1:0] i_addr;
  assign i_addr = HAW'(i_r - CW'(1));

  always_comb begin
    sts.is_compute = kind_r;
    sts.add_ok     = ({1'b0, e_r.a} < n_eff) && ({1'b0, e_r.b} < n_eff) && (cnt_r < MAXE);
    sts.i_gt1      = (i_r > CW'(1));
    sts.gt         = (heap_q.w > e_r.w);
    sts.clr_last   = ({1'b0, k_r} == n_m1);
    sts.acc_done   = ({1'b0, acc_r} == n_m1);
    sts.empty      = (cnt_r == '0);
    sts.has_child  = (c2 <= {1'b0, cnt_r});
    sts.brk        = (last_r.w <= chosen.w);
    sts.top_bad    = ({1'b0, top_r.a} >= n_eff) || ({1'b0, top_r.b} >= n_eff);
    sts.par_neg    = par_q[CW-1];
    sts.same_root  = (r1_r == r2_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    vcount_nxt     = cfg_wr_en ? cfg_wr_data : vcount_r;
    kind_nxt       = kind_r;
    e_nxt          = e_r;
    top_nxt        = top_r;
    last_nxt       = last_r;
    ch_nxt         = ch_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    v_nxt          = v_r;
    r1_nxt         = r1_r;
    r2_nxt         = r2_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    acc_nxt        = acc_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    heap_we        = 1'b0;
    heap_addr      = '0;
    heap_wdata     = e_r;
    par_we         = 1'b0;
    par_addr       = v_r;
    par_wdata      = '1;

    unique case (cmd.op)
      mstw_pkg::OP_NONE: ;
      mstw_pkg::OP_LOAD: begin
        kind_nxt = in_kind;
        e_nxt.w  = in_edge_weight;
        e_nxt.a  = in_endpoint_a;
        e_nxt.b  = in_endpoint_b;
      end
      mstw_pkg::OP_PUSH_INIT: begin
        cnt_nxt = cnt_r + CW'(1);
        i_nxt   = cnt_r + CW'(1);
      end
      mstw_pkg::OP_PUSH_RD: begin
        heap_addr = HAW'((i_r >> 1) - CW'(1));
      end
      mstw_pkg::OP_PUSH_CMP: begin
        heap_we   = 1'b1;
        heap_addr = i_addr;
        if (heap_q.w > e_r.w) begin
          heap_wdata = heap_q;
          i_nxt      = i_r >> 1;
        end
      end
      mstw_pkg::OP_PUSH_FIN: begin
        heap_we   = 1'b1;
        heap_addr = i_addr;
      end
      mstw_pkg::OP_CLR_INIT: begin
        k_nxt   = '0;
        acc_nxt = '0;
        sum_nxt = '0;
      end
      mstw_pkg::OP_CLR: begin
        par_we    = 1'b1;
        par_addr  = k_r;
        par_wdata = '1;
        k_nxt     = k_r + VW'(1);
      end
      mstw_pkg::OP_POP_TOP: heap_addr = '0;
      mstw_pkg::OP_POP_LAST: begin
        heap_addr = HAW'(cnt_r - CW'(1));
        top_nxt   = heap_q;
      end
      mstw_pkg::OP_POP_INIT: begin
        last_nxt = heap_q;
        cnt_nxt  = cnt_r - CW'(1);
        i_nxt    = CW'(1);
      end
      mstw_pkg::OP_SD_RD1: heap_addr = HAW'(c2 - (CW+1)'(1));
      mstw_pkg::OP_SD_RD2: begin
        heap_addr = c2[HAW-1:0];
        ch_nxt    = heap_q;
      end
      mstw_pkg::OP_SD_CMP: begin
        if (!(last_r.w <= chosen.w)) begin
          heap_we    = 1'b1;
          heap_addr  = i_addr;
          heap_wdata = chosen;
          i_nxt      = chosen_idx[CW-1:0];
        end
      end
      mstw_pkg::OP_POP_FIN: begin
        heap_we    = 1'b1;
        heap_addr  = i_addr;
        heap_wdata = last_r;
      end
      mstw_pkg::OP_FA_INIT: v_nxt = top_r.a;
      mstw_pkg::OP_FB_INIT: v_nxt = top_r.b;
      mstw_pkg::OP_FIND_RD: par_addr = v_r;
      mstw_pkg::OP_FA_CHK: begin
        if (par_q[CW-1]) begin
          r1_nxt = v_r;
          p1_nxt = par_q;
        end else begin
          v_nxt = par_q[VW-1:0];
        end
      end
      mstw_pkg::OP_FB_CHK: begin
        if (par_q[CW-1]) begin
          r2_nxt = v_r;
          p2_nxt = par_q;
        end else begin
          v_nxt = par_q[VW-1:0];
        end
      end
      mstw_pkg::OP_UN1: begin
        par_we    = 1'b1;
        par_addr  = big_root;
        par_wdata = p1_r + p2_r;
      end
      mstw_pkg::OP_UN2: begin
        par_we    = 1'b1;
        par_addr  = small_root;
        par_wdata = {1'b0, big_root};
        acc_nxt   = acc_r + VW'(1);
        sum_nxt   = sum_r + SW'(top_r.w);
      end
      mstw_pkg::OP_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ({1'b0, acc_r} != n_m1);
        out_total_nxt  = ({1'b0, acc_r} != n_m1) ? '0 : sum_r;
        cnt_nxt        = '0;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_total_weight = out_total_r;

endmodule

`default_nettype wire

>>> src/minimum_spanning_tree_weight.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight
// Kruskal spanning tree weight over an edge min-heap and a union-find store.
// ----------------------------------------------------------------------------
// Add-edge: a parent read and compare per heap level sifted up, until the new edge settles.
// Compute: clears the union-find store, then per popped edge reads the top and last
//   entries, sifts down with two child reads per level, and walks both find chains.
// One transaction at a time; single-port heap and parent memories set the pace.
// Synchronous active-low reset: vertex_count 1, empty heap, no result pending.
`default_nettype none

module minimum_spanning_tree_weight (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [mstw_pkg::CW-1:0] cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_kind,
  input  wire logic [mstw_pkg::VW-1:0] in_endpoint_a,
  input  wire logic [mstw_pkg::VW-1:0] in_endpoint_b,
  input  wire logic [mstw_pkg::WW-1:0] in_edge_weight,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_status,
  output logic [mstw_pkg::SW-1:0]      out_total_weight
);

  mstw_pkg::mstw_cmd_t cmd;
  mstw_pkg::mstw_sts_t sts;

  mstw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mstw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_kind          (in_kind),
    .in_endpoint_a    (in_endpoint_a),
    .in_endpoint_b    (in_endpoint_b),
    .in_edge_weight   (in_edge_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_total_weight (out_total_weight)
  );

endmodule

`default_nettype wire

>>> tb/mstw_checker.sv
// ----------------------------------------------------------------------------
// mstw_checker
// Watches both channels, predicts the spanning tree weight of each compute
// transaction from its own heap and union-find copy, and compares results.
// ----------------------------------------------------------------------------
module mstw_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [mstw_pkg::CW-1:0] cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_kind,
  input  logic [mstw_pkg::VW-1:0] in_endpoint_a,
  input  logic [mstw_pkg::VW-1:0] in_endpoint_b,
  input  logic [mstw_pkg::WW-1:0] in_edge_weight,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_status,
  input  logic [mstw_pkg::SW-1:0] out_total_weight,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          status;
    logic [25:0]   total;
  } tree_result_t;

  typedef struct {
    int unsigned w;
    int unsigned a;
    int unsigned b;
  } edge_t;

  int unsigned vcount;
  edge_t       heap [1:1024];
  int unsigned hcount;
  int          link [0:1023];
  tree_result_t tree_q [$];

  function automatic int unsigned eff_vertices();
    if (vcount < 1) return 1;
    if (vcount > 1024) return 1024;
    return vcount;
  endfunction

  function automatic void push_edge(edge_t e);
    int unsigned i;
    if (hcount >= 1024) return;
    hcount++;
    i = hcount;
    while (i > 1 && heap[i / 2].w > e.w) begin
      heap[i] = heap[i / 2];
      i = i / 2;
    end
    heap[i] = e;
  endfunction

  function automatic edge_t pop_edge();
    edge_t top, last;
    int unsigned p, c;
    top = heap[1];
    last = heap[hcount];
    p = 1;
    hcount--;
    while (p * 2 <= hcount) begin
      c = p * 2;
      if (c != hcount && heap[c + 1].w < heap[c].w) c++;
      if (last.w <= heap[c].w) break;
      heap[p] = heap[c];
      p = c;
    end
    heap[p] = last;
    return top;
  endfunction

  function automatic int unsigned root_of(int unsigned v);
    int unsigned steps;
    steps = 0;
    while (link[v] >= 0 && steps < 1024) begin
      v = link[v];
      steps++;
    end
    return v;
  endfunction

  function automatic tree_result_t spanning_weight();
    int unsigned n, taken, r1, r2;
    logic [25:0] sum;
    edge_t e;
    tree_result_t r;
    n = eff_vertices();
    for (int i = 0; i < 1024; i++) link[i] = -1;
    taken = 0;
    sum = '0;
    while (taken < n - 1 && hcount > 0) begin
      e = pop_edge();
      if (e.a >= n || e.b >= n) continue;
      r1 = root_of(e.a);
      r2 = root_of(e.b);
      if (r1 == r2) continue;
      if (link[r1] < link[r2]) begin
        link[r1] += link[r2];
        link[r2] = r1;
      end else begin
        link[r2] += link[r1];
        link[r1] = r2;
      end
      taken++;
      sum = sum + 26'(e.w);
    end
    r.status = (taken < n - 1);
    r.total = r.status ? '0 : sum;
    hcount = 0;
    return r;
  endfunction

  assign pending_count = tree_q.size();

  always @(posedge clk) begin
    edge_t e;
    tree_result_t exp_r;
    if (!rst_n) begin
      vcount = 1;
      hcount = 0;
      tree_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) vcount = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_kind == 1'b0) begin
          e.a = in_endpoint_a;
          e.b = in_endpoint_b;
          e.w = in_edge_weight;
          if (e.a < eff_vertices() && e.b < eff_vertices()) push_edge(e);
        end else begin
          tree_q.insert(tree_q.size(), spanning_weight());
        end
      end
      if (out_valid && !out_stall) begin
        if (tree_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status %0d total %0d",
                     out_status, out_total_weight);
        end else begin
          exp_r = tree_q.pop_front();
          if (exp_r.status !== out_status || exp_r.total !== out_total_weight) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected status %0d total %0d, got status %0d total %0d",
                       exp_r.status, exp_r.total, out_status, out_total_weight);
          end
        end
      end
    end
  end
endmodule

>>> tb/minimum_spanning_tree_weight_tb.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight_tb
// Drives edge loads and compute transactions at several vertex counts and
// idling mixes; the checker predicts and compares each reported weight.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [mstw_pkg::CW-1:0] cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_kind;
  logic [mstw_pkg::VW-1:0] in_endpoint_a;
  logic [mstw_pkg::VW-1:0] in_endpoint_b;
  logic [mstw_pkg::WW-1:0] in_edge_weight;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_status;
  logic [mstw_pkg::SW-1:0] out_total_weight;
  int                      fail_count;
  int                      pending_count;
  int                      send_idle_pct;
  int                      stall_pct;
  int                      cycles;

  minimum_spanning_tree_weight uut (.*);
  mstw_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one transaction; payload held until accepted
  task automatic send(input logic kind, input int unsigned a, input int unsigned b,
                      input int unsigned w);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid        = 1'b1;
    in_kind        <= kind;
    in_endpoint_a  <= a[9:0];
    in_endpoint_b  <= b[9:0];
    in_edge_weight <= w[15:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic set_vertices(input int unsigned n);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[10:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random graph: mostly in-range edges, some out of range, then compute
  task automatic random_graph(input int unsigned n, input int unsigned edges);
    int unsigned a, b;
    for (int i = 0; i < edges; i++) begin
      a = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
      b = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
      send(1'b0, a, b, ($urandom_range(3) == 0) ? $urandom : $urandom_range(20));
    end
    send(1'b1, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_endpoint_a = '0;
    in_endpoint_b = '0;
    in_edge_weight = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single vertex at reset count, then an empty heap
    send(1'b0, 0, 0, 16'hFFFF);
    send(1'b1, 0, 0, 0);
    set_vertices(0);
    send(1'b1, 1023, 1023, 16'hFFFF);
    set_vertices(4);
    send(1'b0, 0, 1, 16'hFFFF);
    send(1'b0, 1, 2, 0);
    send(1'b0, 2, 2, 5);
    send(1'b0, 2, 3, 16'hFFFF);
    send(1'b0, 3, 1023, 1);
    send(1'b0, 0, 3, 7);
    send(1'b1, 0, 0, 0);
    send(1'b0, 0, 1, 3);
    send(1'b1, 0, 0, 0);
    // count lowered after loading: edges to vertex 3 are dropped at compute
    send(1'b0, 0, 1, 1);
    send(1'b0, 1, 2, 2);
    send(1'b0, 2, 3, 3);
    set_vertices(3);
    send(1'b1, 0, 0, 0);
    set_vertices(2047);
    send(1'b0, 1023, 0, 16'h8000);
    send(1'b0, 1022, 1023, 16'h7FFF);
    send(1'b1, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
      n = $urandom_range(2, 12);
      set_vertices(n);
      for (int g = 0; g < 8; g++) begin
        if (g == 4) begin
          n = $urandom_range(1, 16);
          set_vertices(n);
        end
        random_graph(n, $urandom_range(0, 3 * n));
      end
    end

    drain();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

>>> sim.f
src/mstw_pkg.sv
src/mstw_ctrl.sv
src/mstw_dp.sv
src/minimum_spanning_tree_weight.sv
tb/mstw_checker.sv
tb/minimum_spanning_tree_weight_tb.sv
